// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port checker of the frame slave.
// Each macro clocks on clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define SCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define SCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/scf_pkg.sv -----
// Shared types and constants for the serial command frame slave.
// Used by scf_emit, the top level and the port checker; depends on nothing.
`timescale 1ns / 1ps

package scf_pkg;

  // Frame protocol bytes and command codes.
  localparam logic [7:0] START_BYTE     = 8'h41;
  localparam logic [7:0] PAD_BYTE       = 8'hff;
  localparam logic [7:0] BROADCAST_ADDR = 8'hff;
  localparam logic [7:0] CMD_ECHO       = 8'd0;
  localparam logic [7:0] CMD_SET_ID     = 8'd254;
  localparam logic [7:0] CMD_ASK_ID     = 8'd253;
  localparam logic [7:0] CMD_ID_REPLY   = 8'd250;

  // Reset value of the node id.
  localparam logic [7:0] INITIAL_ID_RESET = 8'd10;

  // Result kinds, carried on m_tuser.
  localparam logic [1:0] KIND_REPLY   = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_STORE   = 2'd2;

  // Width of the packed result beat.
  localparam int unsigned OUT_DATA_W = 48;

  // Receive parser phase.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_ADDR = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // What a completed frame asks the result sequencer to send.
  typedef enum logic [1:0] {
    JOB_REPLY       = 2'd0,
    JOB_STORE       = 2'd1,
    JOB_STORE_REPLY = 2'd2,
    JOB_REQUEST     = 2'd3
  } job_kind_t;

  // One job handed from the parser to the result sequencer.
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] id;         // id in the reply frame, or the new id to store
    logic [7:0] cmd;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] sum;        // reply checksum
    logic       broadcast;
  } job_t;

endpackage

// ----- hdl/serial_command_frame_slave_core.sv -----
// Top level of the serial command frame slave: receive parser and node id.
// Depends on scf_pkg and instantiates scf_emit.
`timescale 1ns / 1ps

// Received bytes are taken one per cycle while the result sequencer is idle. A
// byte that completes a frame with a good sum starts a burst of one to nine
// result beats (none for a broadcast echo), which leave through the output
// register one per cycle while the sink keeps up; the input is held off until
// the sequencer in scf_emit has issued the last beat of the burst. No clearing
// pass is needed after reset.
module serial_command_frame_slave_core (
  input  logic                              clk,
  input  logic                              rst,
  // Node id register.
  input  logic                              cfg_we,
  input  logic [7:0]                        cfg_wdata,
  // Received bytes.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
  // Result beats.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [7:0] tx_byte, [15:8] req_cmd, [31:16] req_data, [32] req_broadcast,
  // [40:33] stored_id, [47:41] zero
  output logic [scf_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [1:0]                        m_tuser,   // [1:0] kind
  output logic                              m_tlast
);

  scf_pkg::phase_t phase;
  scf_pkg::phase_t phase_next;
  logic [2:0]      byte_index;
  logic [2:0]      byte_index_next;
  logic [7:0]      own_id;
  logic [7:0]      own_id_next;
  logic [7:0]      frame_bytes [4];
  logic            frame_wr;
  logic            accept;
  logic            busy;
  logic            job_load;
  scf_pkg::job_t   job;
  logic [9:0]      rx_sum_wide;
  logic [7:0]      rx_sum;
  logic            broadcast;
  logic [7:0]      reply_id;
  logic [9:0]      reply_sum_wide;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !busy;

  // Frame checksum and broadcast test.
  assign rx_sum_wide = {2'b00, frame_bytes[0]} + {2'b00, frame_bytes[1]} +
                       {2'b00, frame_bytes[2]} + {2'b00, frame_bytes[3]};
  assign rx_sum      = rx_sum_wide[7:0];
  assign broadcast   = (frame_bytes[0] == scf_pkg::BROADCAST_ADDR);

  // Next state of the parser.
  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    frame_wr        = 1'b0;
    if (accept) begin
      unique case (phase)
        scf_pkg::PH_ADDR: begin
          if (s_tdata == own_id || s_tdata == scf_pkg::BROADCAST_ADDR) begin
            frame_wr        = 1'b1;
            byte_index_next = 3'd1;
            phase_next      = scf_pkg::PH_BODY;
          end else begin
            phase_next = scf_pkg::PH_HUNT;
          end
        end
        scf_pkg::PH_BODY: begin
          if (byte_index < 3'd4) begin
            frame_wr        = 1'b1;
            byte_index_next = byte_index + 3'd1;
          end else begin
            phase_next      = scf_pkg::PH_HUNT;
            byte_index_next = 3'd0;
          end
        end
        default: begin
          phase_next = scf_pkg::PH_HUNT;
          if (s_tdata == scf_pkg::START_BYTE) begin
            phase_next      = scf_pkg::PH_ADDR;
            byte_index_next = 3'd0;
          end
        end
      endcase
    end
  end

  // Job for the result sequencer and id update on a good frame.
  always_comb begin
    job_load    = 1'b0;
    own_id_next = own_id;
    reply_id    = own_id;
    job.kind    = scf_pkg::JOB_REQUEST;
    job.cmd     = frame_bytes[1];
    job.lo      = frame_bytes[2];
    job.hi      = frame_bytes[3];
    job.broadcast = broadcast;
    if (accept && phase == scf_pkg::PH_BODY && byte_index >= 3'd4 &&
        rx_sum == s_tdata) begin
      priority if (frame_bytes[1] == scf_pkg::CMD_ECHO) begin
        job.kind = scf_pkg::JOB_REPLY;
        job_load = !broadcast;
      end else if (frame_bytes[1] == scf_pkg::CMD_SET_ID) begin
        own_id_next = frame_bytes[2];
        reply_id    = frame_bytes[2];
        job.kind    = broadcast ? scf_pkg::JOB_STORE : scf_pkg::JOB_STORE_REPLY;
        job_load    = 1'b1;
      end else if (frame_bytes[1] == scf_pkg::CMD_ASK_ID) begin
        job.kind = scf_pkg::JOB_REPLY;
        job.cmd  = scf_pkg::CMD_ID_REPLY;
        job.lo   = own_id;
        job.hi   = 8'h00;
        job_load = 1'b1;
      end else begin
        job.kind = scf_pkg::JOB_REQUEST;
        job_load = 1'b1;
      end
    end
    if (cfg_we) begin
      own_id_next = cfg_wdata;
    end
    // Reply id and checksum over the final reply fields.
    reply_sum_wide = {2'b00, reply_id} + {2'b00, job.cmd} +
                     {2'b00, job.lo} + {2'b00, job.hi};
    job.id  = reply_id;
    job.sum = reply_sum_wide[7:0];
  end

  // Parser state and node id.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= scf_pkg::PH_HUNT;
      byte_index <= 3'd0;
      own_id     <= scf_pkg::INITIAL_ID_RESET;
    end else begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
      own_id     <= own_id_next;
    end
  end

  // Frame byte store, written at the current byte position.
  always_ff @(posedge clk) begin
    if (frame_wr) begin
      frame_bytes[byte_index_next[1:0] - 2'd1] <= s_tdata;
    end
  end

  scf_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .job_load (job_load),
    .job_in   (job),
    .busy     (busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- hdl/scf_emit.sv -----
// Result sequencer of the frame slave: turns one job into its result beats.
// Depends on scf_pkg for the job type and the result kinds.
`timescale 1ns / 1ps

module scf_emit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_load,
  input  scf_pkg::job_t                     job_in,
  output logic                              busy,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [scf_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [1:0]                        m_tuser,
  output logic                              m_tlast
);

  scf_pkg::job_t job;
  logic [3:0]    step;
  logic          out_free;
  logic          has_store;
  logic [3:0]    final_step;
  logic [3:0]    reply_idx;
  logic [7:0]    tx_byte;
  logic [7:0]    req_cmd;
  logic [15:0]   req_data;
  logic          req_broadcast;
  logic [7:0]    stored_id;
  logic [1:0]    kind;

  assign out_free = !m_tvalid || m_tready;

  // Beat count and leading store beat of each job kind.
  always_comb begin
    unique case (job.kind)
      scf_pkg::JOB_REPLY: begin
        has_store  = 1'b0;
        final_step = 4'd7;
      end
      scf_pkg::JOB_STORE: begin
        has_store  = 1'b1;
        final_step = 4'd0;
      end
      scf_pkg::JOB_STORE_REPLY: begin
        has_store  = 1'b1;
        final_step = 4'd8;
      end
      scf_pkg::JOB_REQUEST: begin
        has_store  = 1'b0;
        final_step = 4'd0;
      end
    endcase
  end

  assign reply_idx = step - {3'b000, has_store};

  // Fields of the beat at the current step.
  always_comb begin
    tx_byte       = 8'h00;
    req_cmd       = 8'h00;
    req_data      = 16'h0000;
    req_broadcast = 1'b0;
    stored_id     = 8'h00;
    kind          = scf_pkg::KIND_REPLY;
    if (job.kind == scf_pkg::JOB_REQUEST) begin
      kind          = scf_pkg::KIND_REQUEST;
      req_cmd       = job.cmd;
      req_data      = {job.hi, job.lo};
      req_broadcast = job.broadcast;
    end else if (has_store && step == 4'd0) begin
      kind      = scf_pkg::KIND_STORE;
      stored_id = job.id;
    end else begin
      unique case (reply_idx[2:0])
        3'd0: tx_byte = scf_pkg::PAD_BYTE;
        3'd1: tx_byte = scf_pkg::START_BYTE;
        3'd2: tx_byte = job.id;
        3'd3: tx_byte = job.cmd;
        3'd4: tx_byte = job.lo;
        3'd5: tx_byte = job.hi;
        3'd6: tx_byte = job.sum;
        3'd7: tx_byte = scf_pkg::PAD_BYTE;
      endcase
    end
  end

  // Job register and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 4'd0;
    end else if (job_load) begin
      busy <= 1'b1;
      step <= 4'd0;
    end else if (busy && out_free) begin
      if (step == final_step) begin
        busy <= 1'b0;
      end
      step <= step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job <= job_in;
    end
  end

  // Output register: one result beat per cycle while the sink keeps up.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (busy && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && out_free) begin
      m_tdata <= {7'b0000000, stored_id, req_broadcast, req_data, req_cmd, tx_byte};
      m_tuser <= kind;
      m_tlast <= (step == final_step);
    end
  end

endmodule

// ----- hdl/scf_checker.sv -----
// Port checker for the serial command frame slave, bound to the top level.
// Depends on scf_pkg and on the macros in assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [scf_pkg::OUT_DATA_W-1:0]    m_tdata,
  input logic [1:0]                        m_tuser,
  input logic                              m_tlast
);

  logic req_beat;
  logic store_beat;

  assign req_beat   = m_tvalid && m_tuser == scf_pkg::KIND_REQUEST;
  assign store_beat = m_tvalid && m_tuser == scf_pkg::KIND_STORE;

  // A stalled result beat stays offered.
  `SCF_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result beat dropped")

  // Only the three defined result kinds appear.
  `SCF_ASSERT_NOW(a_kind_range, m_tvalid, m_tuser <= scf_pkg::KIND_STORE, "undefined kind")

  // An application request is always the only and final beat of its burst.
  `SCF_ASSERT_NOW(a_req_last, req_beat, m_tlast, "request beat not last")

  // A store beat is followed by reply bytes unless the frame was a broadcast, so it
  // is last only then, and it never carries a transmit byte.
  `SCF_ASSERT_NOW(a_store_clean, store_beat, m_tdata[7:0] == 8'h00, "store beat has tx byte")

endmodule

bind serial_command_frame_slave_core scf_checker u_scf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
